// File: sv/rne_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and digit helpers for the Roman numeral encoder.
// Depends on nothing; every other file uses it.
package rne_pkg;

  localparam int unsigned VALUE_W     = 13;
  localparam int unsigned SYM_W       = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 13'd1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 13'd4999;

  // place weights, held at 14 bits so nine times a weight cannot wrap
  localparam logic [13:0] W_THOUSAND = 14'd1000;
  localparam logic [13:0] W_HUNDRED  = 14'd100;
  localparam logic [13:0] W_TEN      = 14'd10;

  typedef enum logic [SYM_W-1:0] {
    SYM_I = 3'd0,
    SYM_V = 3'd1,
    SYM_X = 3'd2,
    SYM_L = 3'd3,
    SYM_C = 3'd4,
    SYM_D = 3'd5,
    SYM_M = 3'd6
  } rne_sym_e;

  typedef enum logic [1:0] {
    PL_TH = 2'd0,
    PL_HU = 2'd1,
    PL_TE = 2'd2,
    PL_ON = 2'd3
  } rne_place_e;

  // one classified request: range error plus the four decimal digits
  typedef struct packed {
    logic               err;
    logic [2:0]         th;
    logic [DIGIT_W-1:0] hu;
    logic [DIGIT_W-1:0] te;
    logic [DIGIT_W-1:0] on;
  } rne_digits_t;

  // count how many whole weights fit in r, for r below ten weights
  function automatic logic [DIGIT_W-1:0] digit_count(input logic [13:0] r,
                                                     input logic [13:0] w);
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 14'(14'(k) * w)) d = DIGIT_W'(k);
    end
    return d;
  endfunction

  // number of symbols a hundreds, tens or ones digit expands into
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd2, 4'd3: n = d[2:0];
      4'd4:             n = 3'd2;
      4'd5:             n = 3'd1;
      4'd6, 4'd7, 4'd8: n = 3'(d - 4'd4);
      4'd9:             n = 3'd2;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol k of a digit, given the one, five and ten symbols of its place
  function automatic rne_sym_e digit_sym(input logic [DIGIT_W-1:0] d,
                                         input logic [1:0] k,
                                         input rne_sym_e one,
                                         input rne_sym_e five,
                                         input rne_sym_e ten);
    rne_sym_e s;
    unique case (d)
      4'd4:                   s = (k == 2'd0) ? one : five;
      4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? five : one;
      4'd9:                   s = (k == 2'd0) ? one : ten;
      default:                s = one;
    endcase
    return s;
  endfunction

endpackage

// File: sv/rne_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the encoder input and symbol output.
// Depends on rne_pkg for field widths.
interface rne_in_if;
  logic                       valid;
  logic                       ready;
  logic [rne_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if;
  logic                     valid;
  logic                     ready;
  logic [rne_pkg::SYM_W-1:0] symbol;
  logic                     last;
  logic                     error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

// File: sv/rne_front.sv
`timescale 1ns / 1ps
// Front end: accepts values, checks range and splits them into decimal digits.
// Depends on rne_pkg and rne_in_if; feeds rne_queue.
module rne_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rne_in_if.sink               in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output rne_pkg::rne_digits_t push_data_o
);
  import rne_pkg::*;

  logic        s1_v_q, s2_v_q;
  logic        s1_err_q, s2_err_q;
  logic [2:0]  s1_th_q, s2_th_q;
  logic [9:0]  s1_rem_q;
  logic [3:0]  s2_hu_q;
  logic [6:0]  s2_rem_q;
  logic        en1, en2;
  logic        in_err;
  logic [3:0]  th_d, hu_d, te_d;
  logic [13:0] v_ext, r1_ext, r2_ext;

  // stall the whole front when the queue is full
  assign en2       = !s2_v_q || push_ready_i;
  assign en1       = !s1_v_q || en2;
  assign in_i.ready = en1;

  // stage one: range check and thousands digit
  assign v_ext  = {1'b0, in_i.value};
  assign in_err = (in_i.value < VALUE_MIN) || (in_i.value > VALUE_MAX);
  assign th_d   = digit_count(v_ext, W_THOUSAND);

  // stage two: hundreds digit
  assign r1_ext = {4'b0, s1_rem_q};
  assign hu_d   = digit_count(r1_ext, W_HUNDRED);

  // push path: tens and ones digits
  assign r2_ext = {7'b0, s2_rem_q};
  assign te_d   = digit_count(r2_ext, W_TEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_i.valid;
      if (en2) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_err_q <= in_err;
      s1_th_q  <= th_d[2:0];
      s1_rem_q <= 10'(v_ext - 14'(14'(th_d) * W_THOUSAND));
    end
    if (en2 && s1_v_q) begin
      s2_err_q <= s1_err_q;
      s2_th_q  <= s1_th_q;
      s2_hu_q  <= hu_d;
      s2_rem_q <= 7'(r1_ext - 14'(14'(hu_d) * W_HUNDRED));
    end
  end

  assign push_valid_o    = s2_v_q;
  assign push_data_o.err = s2_err_q;
  assign push_data_o.th  = s2_th_q;
  assign push_data_o.hu  = s2_hu_q;
  assign push_data_o.te  = te_d;
  assign push_data_o.on  = 4'(r2_ext - 14'(14'(te_d) * W_TEN));

endmodule

// File: sv/rne_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified requests between the front and back ends.
// Depends on rne_pkg for the request record type.
module rne_queue #(
  parameter int unsigned DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  rne_pkg::rne_digits_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output rne_pkg::rne_digits_t pop_data_o
);
  import rne_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rne_digits_t        mem_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // store the request
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue occupancy exceeds depth");

endmodule

// File: sv/rne_back.sv
`timescale 1ns / 1ps
// Back end: walks a digit record and emits one numeral symbol per cycle while the output is ready.
// Depends on rne_pkg and rne_out_if; pulls from rne_queue.
module rne_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rne_pkg::rne_digits_t q_data_i,
  rne_out_if.source            out_o
);
  import rne_pkg::*;

  logic        busy_q;
  rne_digits_t rec_q;
  rne_place_e  place_q, place_d;
  logic [1:0]  k_q;
  logic        ov_q, last_q, err_q;
  rne_sym_e    sym_q;

  logic [2:0]  len_c [4];
  logic [2:0]  len_n [4];
  logic [3:0]  nz_c, nz_n, above;
  logic [2:0]  cur_len;
  logic        emit, end_digit, has_next, finish, load;
  rne_place_e  next_place, first_place;
  rne_sym_e    cur_sym;

  // symbol counts per place, for the current and the incoming record
  assign len_c[0] = rec_q.th;
  assign len_c[1] = digit_len(rec_q.hu);
  assign len_c[2] = digit_len(rec_q.te);
  assign len_c[3] = digit_len(rec_q.on);
  assign len_n[0] = q_data_i.th;
  assign len_n[1] = digit_len(q_data_i.hu);
  assign len_n[2] = digit_len(q_data_i.te);
  assign len_n[3] = digit_len(q_data_i.on);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz_c[i]  = (len_c[i] != 3'd0);
      nz_n[i]  = (len_n[i] != 3'd0);
      above[i] = nz_c[i] && (2'(i) > place_q);
    end
  end

  // find the next place that has symbols
  always_comb begin
    next_place = PL_ON;
    priority if (above[1]) next_place = PL_HU;
    else if (above[2])     next_place = PL_TE;
    else if (above[3])     next_place = PL_ON;
    else                   next_place = PL_ON;
  end

  always_comb begin
    first_place = PL_ON;
    priority if (nz_n[0]) first_place = PL_TH;
    else if (nz_n[1])     first_place = PL_HU;
    else if (nz_n[2])     first_place = PL_TE;
    else                  first_place = PL_ON;
  end

  // current symbol
  always_comb begin
    cur_sym = SYM_I;
    unique case (place_q)
      PL_TH: cur_sym = SYM_M;
      PL_HU: cur_sym = digit_sym(rec_q.hu, k_q, SYM_C, SYM_D, SYM_M);
      PL_TE: cur_sym = digit_sym(rec_q.te, k_q, SYM_X, SYM_L, SYM_C);
      PL_ON: cur_sym = digit_sym(rec_q.on, k_q, SYM_I, SYM_V, SYM_X);
      default: cur_sym = SYM_I;
    endcase
  end

  assign cur_len   = len_c[place_q];
  assign has_next  = |above;
  assign end_digit = ({1'b0, k_q} == 3'(cur_len - 3'd1));
  assign emit      = busy_q && (!ov_q || out_o.ready);
  assign finish    = rec_q.err || (end_digit && !has_next);
  assign q_ready_o = !busy_q || (emit && finish);
  assign load      = q_valid_i && q_ready_o;
  assign place_d   = load ? first_place : next_place;

  // sequence through places and repeats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      place_q <= PL_TH;
      k_q     <= '0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        place_q <= place_d;
        k_q     <= '0;
      end else if (emit) begin
        if (finish) begin
          busy_q <= 1'b0;
        end else if (end_digit) begin
          place_q <= place_d;
          k_q     <= '0;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) rec_q <= q_data_i;
  end

  // hold the emitted symbol until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sym_q  <= rec_q.err ? SYM_I : cur_sym;
      last_q <= finish;
      err_q  <= rec_q.err;
    end
  end

  assign out_o.valid  = ov_q;
  assign out_o.symbol = sym_q;
  assign out_o.last   = last_q;
  assign out_o.error  = err_q;

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && err_q |-> last_q && (sym_q == SYM_I))
    else $error("error result without last or with a symbol");

  a_has_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !rec_q.err |-> ({1'b0, k_q} < cur_len))
    else $error("sequencer sits on a place with no symbol left");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q)
    else $error("loaded request did not start");

endmodule

// File: sv/roman_numeral_encoder_unit.sv
`timescale 1ns / 1ps
// Roman numeral encoder: value in, one symbol per output request, last marked.
// A value passes front stages s1 and s2, the queue, the back-end record register and the output symbol register.
// Throughput: one symbol per cycle while the output is ready; a value holds the back end
// until all its symbols (1 to 16) are out, from the single-symbol output sequencer.
// Reset: asynchronous active low, empties the pipeline, queue and output; no clearing pass.
module roman_numeral_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rne_in_if.sink    in_i,
  rne_out_if.source out_o
);
  import rne_pkg::*;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  rne_digits_t push_data, pop_data;

  // classify and split into digits
  rne_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouple front and back
  rne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // expand digits into symbols
  rne_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_data_i  (pop_data),
    .out_o     (out_o)
  );

endmodule
